// File: hdl/rte_pkg.sv
package rte_pkg;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned DELTA_W = 32;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned US_W    = 27;
  localparam int unsigned VAR_W   = 22;
  localparam int unsigned OUT_W   = 31;
  localparam int unsigned SUM_W   = 36;

  localparam logic [1:0] CFG_INITIAL_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_MIN_TIMEOUT     = 2'd1;
  localparam logic [1:0] CFG_MAX_TIMEOUT     = 2'd2;
  localparam logic [1:0] CFG_SCAN_DELAY      = 2'd3;

  localparam logic [US_W-1:0] US_PER_MS = US_W'(1000);

  localparam logic [US_W-1:0] RST_MIN_US   = US_W'(100000);
  localparam logic [US_W-1:0] RST_MAX_US   = US_W'(10000000);
  localparam logic [US_W-1:0] RST_DELAY_US = US_W'(0);

  localparam logic signed [DELTA_W-1:0] NEG_TOLERANCE   = DELTA_W'(-50000);
  localparam logic signed [DELTA_W-1:0] NEG_REPLACEMENT = DELTA_W'(10000);
  localparam logic signed [DELTA_W-1:0] DELTA_LIMIT     = DELTA_W'(8000000);
  localparam logic signed [DELTA_W-1:0] VAR_FLOOR       = DELTA_W'(5000);
  localparam logic signed [DELTA_W-1:0] VAR_SEED_CAP    = DELTA_W'(2000000);
  localparam logic signed [SUM_W-1:0]   JUMP_LIMIT      = SUM_W'(1500000);
  localparam logic signed [SUM_W-1:0]   VAR_CAP_TRIGGER = SUM_W'(2300000);
  localparam logic [VAR_W-1:0]          VAR_CAP_VALUE   = VAR_W'(2000000);

  typedef enum logic [1:0] {
    STATUS_SEEDED       = 2'd0,
    STATUS_ACCEPTED     = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2,
    STATUS_BOGUS_JUMP   = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic                      out_of_range;
  } sample_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  function automatic logic [US_W-1:0] ms_to_us(input logic [CFG_W-1:0] ms);
    ms_to_us = US_W'(ms) * US_PER_MS;
  endfunction

endpackage

// File: hdl/rte_in_if.sv
interface rte_in_if;
  logic                          valid;
  logic                          ready;
  logic [rte_pkg::TIME_W-1:0]    sent_time_us;
  logic [rte_pkg::TIME_W-1:0]    recv_time_us;

  modport source (output valid, output sent_time_us, output recv_time_us, input ready);
  modport sink (input valid, input sent_time_us, input recv_time_us, output ready);
endinterface

// File: hdl/rte_out_if.sv
interface rte_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rte_pkg::DELTA_W-1:0] smoothed_rtt_us;
  logic [rte_pkg::OUT_W-1:0]         rtt_variance_us;
  logic [rte_pkg::OUT_W-1:0]         timeout_us;
  logic [1:0]                        sample_status;

  modport source (output valid, output smoothed_rtt_us, output rtt_variance_us,
                  output timeout_us, output sample_status, input ready);
  modport sink (input valid, input smoothed_rtt_us, input rtt_variance_us,
                input timeout_us, input sample_status, output ready);
endinterface

// File: hdl/rte_front.sv
module rte_front (
  input  logic [rte_pkg::TIME_W-1:0] sent_time_us,
  input  logic [rte_pkg::TIME_W-1:0] recv_time_us,
  output rte_pkg::sample_t           sample
);

  logic signed [rte_pkg::TIME_W:0]    diff;
  logic signed [rte_pkg::DELTA_W-1:0] sat;
  logic signed [rte_pkg::DELTA_W-1:0] delta;

  localparam logic signed [rte_pkg::TIME_W:0] SAT_MAX =
    (rte_pkg::TIME_W+1)'({1'b0, {(rte_pkg::DELTA_W-1){1'b1}}});
  localparam logic signed [rte_pkg::TIME_W:0] SAT_MIN = -SAT_MAX - 1;

  always_comb begin
    diff = $signed({1'b0, recv_time_us}) - $signed({1'b0, sent_time_us});
    if (diff > SAT_MAX) begin
      sat = SAT_MAX[rte_pkg::DELTA_W-1:0];
    end else if (diff < SAT_MIN) begin
      sat = SAT_MIN[rte_pkg::DELTA_W-1:0];
    end else begin
      sat = diff[rte_pkg::DELTA_W-1:0];
    end
    // Small negative deltas come from clock jitter and are replaced.
    if (sat < 0 && sat > rte_pkg::NEG_TOLERANCE) begin
      delta = rte_pkg::NEG_REPLACEMENT;
    end else begin
      delta = sat;
    end
    sample.delta        = delta;
    sample.out_of_range = (delta >= rte_pkg::DELTA_LIMIT) || (delta < 0);
  end

endmodule

// File: hdl/rte_queue.sv
module rte_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rte_pkg::queue_ctrl_t ctrl,
  input  rte_pkg::sample_t     wr_item,
  output rte_pkg::sample_t     rd_item,
  output logic                 full,
  output logic                 not_empty
);

  rte_pkg::sample_t entry_r [2];
  logic             wr_ptr_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_r;
  logic             rd_ptr_nxt;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign rd_item   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = ctrl.push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = ctrl.pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(ctrl.push) - 2'(ctrl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !ctrl.push) else $error("push into full queue");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !ctrl.pop) else $error("pop from empty queue");
`endif

endmodule

// File: hdl/rte_back.sv
module rte_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [rte_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         item_valid,
  input  rte_pkg::sample_t             item,
  output logic                         item_pop,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic signed [rte_pkg::DELTA_W-1:0] res_srtt,
  output logic [rte_pkg::OUT_W-1:0]    res_var,
  output logic [rte_pkg::OUT_W-1:0]    res_timeout,
  output rte_pkg::status_t             res_status
);

  localparam int unsigned SW = rte_pkg::SUM_W;

  logic [rte_pkg::US_W-1:0]           min_us_r;
  logic [rte_pkg::US_W-1:0]           max_us_r;
  logic [rte_pkg::US_W-1:0]           delay_us_r;
  logic                               est_valid_r;
  logic signed [rte_pkg::DELTA_W-1:0] srtt_r;
  logic [rte_pkg::VAR_W-1:0]          var_r;
  logic [rte_pkg::US_W-1:0]           tmo_r;
  logic                               out_valid_r;
  rte_pkg::status_t                   status_r;

  logic signed [rte_pkg::DELTA_W-1:0] srtt_nxt;
  logic [rte_pkg::VAR_W-1:0]          var_nxt;
  logic [rte_pkg::US_W-1:0]           tmo_nxt;
  rte_pkg::status_t                   status_nxt;

  logic signed [SW-1:0] delta_w;
  logic signed [SW-1:0] srtt_w;
  logic signed [SW-1:0] var_w;
  logic signed [SW-1:0] diff;
  logic signed [SW-1:0] abs_diff;
  logic signed [SW-1:0] jump_bound;
  logic signed [SW-1:0] srtt_new;
  logic signed [SW-1:0] var_new;
  logic signed [SW-1:0] tmo_raw;
  logic signed [SW-1:0] tmo_clamped;
  logic signed [SW-1:0] lo_w;
  logic signed [SW-1:0] hi_w;
  logic signed [SW-1:0] delay_w;
  logic                 bogus_jump;
  logic                 reject;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_us_r   <= rte_pkg::RST_MIN_US;
      max_us_r   <= rte_pkg::RST_MAX_US;
      delay_us_r <= rte_pkg::RST_DELAY_US;
    end else if (cfg_we) begin
      case (cfg_index)
        rte_pkg::CFG_MIN_TIMEOUT: min_us_r   <= rte_pkg::ms_to_us(cfg_wdata);
        rte_pkg::CFG_MAX_TIMEOUT: max_us_r   <= rte_pkg::ms_to_us(cfg_wdata);
        rte_pkg::CFG_SCAN_DELAY:  delay_us_r <= rte_pkg::ms_to_us(cfg_wdata);
        // The initial timeout only applies before the first sample, and no
        // result is ever reported in that condition, so it is not stored.
        rte_pkg::CFG_INITIAL_TIMEOUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign item_pop = item_valid && (!out_valid_r || res_ready);

  always_comb begin
    delta_w  = SW'(item.delta);
    srtt_w   = SW'(srtt_r);
    var_w    = $signed({{(SW - rte_pkg::VAR_W){1'b0}}, var_r});
    lo_w     = $signed({{(SW - rte_pkg::US_W){1'b0}}, min_us_r});
    hi_w     = $signed({{(SW - rte_pkg::US_W){1'b0}}, max_us_r});
    delay_w  = $signed({{(SW - rte_pkg::US_W){1'b0}}, delay_us_r});

    diff       = delta_w - srtt_w;
    abs_diff   = (diff < 0) ? -diff : diff;
    jump_bound = (srtt_w <<< 1) + srtt_w + (var_w <<< 1);
    bogus_jump = (diff > rte_pkg::JUMP_LIMIT) && (diff > jump_bound);

    if (!est_valid_r) begin
      srtt_new = delta_w;
      if (item.delta < rte_pkg::VAR_FLOOR) begin
        var_new = SW'(rte_pkg::VAR_FLOOR);
      end else if (item.delta > rte_pkg::VAR_SEED_CAP) begin
        var_new = SW'(rte_pkg::VAR_SEED_CAP);
      end else begin
        var_new = delta_w;
      end
    end else begin
      srtt_new = srtt_w + (diff >>> 3);
      var_new  = var_w + ((abs_diff - var_w) >>> 2);
    end

    tmo_raw = srtt_new + (var_new <<< 2);
    if (tmo_raw > hi_w) begin
      tmo_clamped = hi_w;
    end else if (tmo_raw < lo_w) begin
      tmo_clamped = lo_w;
    end else begin
      tmo_clamped = tmo_raw;
    end
    if (delay_us_r != '0 && tmo_clamped < delay_w) begin
      tmo_clamped = delay_w;
    end

    reject = est_valid_r && (item.out_of_range || bogus_jump);

    if (reject) begin
      srtt_nxt   = srtt_r;
      var_nxt    = var_r;
      tmo_nxt    = tmo_r;
      status_nxt = item.out_of_range ? rte_pkg::STATUS_OUT_OF_RANGE
                                     : rte_pkg::STATUS_BOGUS_JUMP;
    end else begin
      srtt_nxt   = srtt_new[rte_pkg::DELTA_W-1:0];
      var_nxt    = (var_new > rte_pkg::VAR_CAP_TRIGGER) ? rte_pkg::VAR_CAP_VALUE
                                                        : var_new[rte_pkg::VAR_W-1:0];
      tmo_nxt    = tmo_clamped[rte_pkg::US_W-1:0];
      status_nxt = est_valid_r ? rte_pkg::STATUS_ACCEPTED : rte_pkg::STATUS_SEEDED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_valid_r <= 1'b0;
      srtt_r      <= '0;
      var_r       <= '0;
      tmo_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_pop) begin
        est_valid_r <= 1'b1;
        srtt_r      <= srtt_nxt;
        var_r       <= var_nxt;
        tmo_r       <= tmo_nxt;
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      status_r <= status_nxt;
    end
  end

  assign res_valid   = out_valid_r;
  assign res_srtt    = srtt_r;
  assign res_var     = rte_pkg::OUT_W'(var_r);
  assign res_timeout = rte_pkg::OUT_W'(tmo_r);
  assign res_status  = status_r;

`ifndef SYNTH
  a_var_capped: assert property (@(posedge clk) disable iff (!rst_n)
    $signed({{(SW - rte_pkg::VAR_W){1'b0}}, var_r}) <= rte_pkg::VAR_CAP_TRIGGER)
    else $error("stored variance above cap trigger");
  a_seed_first: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop && !est_valid_r |=> res_status == rte_pkg::STATUS_SEEDED)
    else $error("first transaction not reported as seed");
  a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop && reject |=> $stable(srtt_r) && $stable(var_r) && $stable(tmo_r))
    else $error("rejected sample changed the estimator state");
  a_pop_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |=> out_valid_r) else $error("result lost after pop");
`endif

endmodule

// File: hdl/rtt_timeout_estimator_core.sv
// Retransmission timeout estimator.
// Input channel in_ch carries one probe per transaction: its send and
// receive timestamps in microseconds. Output channel out_ch returns exactly
// one result transaction per input: smoothed RTT, variance, timeout and a
// status code (seeded, accepted, out of range, bogus jump).
// Both channels use valid/ready; a transaction completes when both are high.
// The front stage forms the saturated delta and flags out-of-range samples
// in the accept cycle; a two-entry queue then feeds the estimator update,
// which is combinational and writes an output register.
// Each input is registered in a queue entry, then in the output register;
// one transaction per cycle is sustained while out_ch.ready stays high.
// When out_ch.ready is low the output register holds its result, the queue
// fills, and in_ch.ready drops once both queue entries are occupied.
// Configuration writes (cfg_we, cfg_index, cfg_wdata in milliseconds) take
// effect from the next cycle and should only be issued while idle.
// Synchronous reset clears the estimator, empties the queue and restores
// the default timeout window.
module rtt_timeout_estimator_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [rte_pkg::CFG_W-1:0] cfg_wdata,
  rte_in_if.sink                    in_ch,
  rte_out_if.source                 out_ch
);

  rte_pkg::sample_t     front_item;
  rte_pkg::sample_t     head_item;
  rte_pkg::queue_ctrl_t q_ctrl;
  logic                 q_full;
  logic                 q_not_empty;
  logic                 pop;
  rte_pkg::status_t     status;

  rte_front u_front (
    .sent_time_us (in_ch.sent_time_us),
    .recv_time_us (in_ch.recv_time_us),
    .sample       (front_item)
  );

  assign in_ch.ready = !q_full;
  assign q_ctrl.push = in_ch.valid && !q_full;
  assign q_ctrl.pop  = pop;

  rte_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (q_ctrl),
    .wr_item   (front_item),
    .rd_item   (head_item),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  rte_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .item_valid  (q_not_empty),
    .item        (head_item),
    .item_pop    (pop),
    .res_valid   (out_ch.valid),
    .res_ready   (out_ch.ready),
    .res_srtt    (out_ch.smoothed_rtt_us),
    .res_var     (out_ch.rtt_variance_us),
    .res_timeout (out_ch.timeout_us),
    .res_status  (status)
  );

  assign out_ch.sample_status = status;

endmodule

// File: verif/tb_top.sv
module tb_top;
  import rte_pkg::*;

  localparam longint INT32_HI      = 64'sd2147483647;
  localparam longint INT32_LO      = -64'sd2147483648;
  localparam longint NEG_WINDOW    = 50000;
  localparam longint NEG_SUBST     = 10000;
  localparam longint DEV_FLOOR     = 5000;
  localparam longint DEV_SEED_MAX  = 2000000;
  localparam longint RTT_CEILING   = 8000000;
  localparam longint JUMP_SPAN     = 1500000;
  localparam longint DEV_TRIP      = 2300000;
  localparam longint DEV_CLIPPED   = 2000000;
  localparam longint STAMP_MAX     = (64'sd1 << 48) - 1;
  localparam int     STALL_LIMIT   = 1000;
  localparam int     RANDOM_PROBES = 400;
  localparam int     WINDOW_ROUNDS = 8;

  typedef struct packed {
    logic signed [31:0] srtt;
    logic [30:0]        rtt_dev;
    logic [30:0]        timeout;
    status_t            status;
  } rtt_result_t;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TRICKLE} rx_pattern_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  rte_in_if  in_if ();
  rte_out_if out_if ();

  rtt_timeout_estimator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  bit               est_valid = 1'b0;
  int               est_srtt = 0;
  int               est_dev = 0;
  int               est_tmo = 0;
  logic [CFG_W-1:0] win_initial_ms = CFG_W'(1000);
  logic [CFG_W-1:0] win_min_ms = CFG_W'(100);
  logic [CFG_W-1:0] win_max_ms = CFG_W'(10000);
  logic [CFG_W-1:0] win_delay_ms = '0;

  rtt_result_t      pending_q[$];
  rtt_result_t      oldest;
  int               gen_srtt = 0;
  int               gen_dev = 0;
  int               errors = 0;
  int               probes_accepted = 0;
  int               windows_applied = 0;
  int               burst_left = 0;
  bit               sender_gaps = 1'b1;
  int               idle_cycles = 0;
  int               status_count [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rtt_result_t estimate_rtt(input logic [TIME_W-1:0] sent,
                                               input logic [TIME_W-1:0] recv);
    longint      delta;
    longint      d;
    longint      srtt_n;
    longint      dev_n;
    longint      tmo;
    longint      lo;
    longint      hi;
    longint      mag;
    status_t     st;
    rtt_result_t r;
    delta = longint'({16'd0, recv}) - longint'({16'd0, sent});
    if (delta > INT32_HI) delta = INT32_HI;
    if (delta < INT32_LO) delta = INT32_LO;
    if (delta < 0 && delta > -NEG_WINDOW) delta = NEG_SUBST;
    d = delta - longint'(est_srtt);
    if (!est_valid) begin
      srtt_n = delta;
      dev_n = (delta < DEV_SEED_MAX) ? delta : DEV_SEED_MAX;
      if (dev_n < DEV_FLOOR) dev_n = DEV_FLOOR;
      st = STATUS_SEEDED;
    end else begin
      if (delta >= RTT_CEILING || delta < 0) begin
        st = STATUS_OUT_OF_RANGE;
      end else if (d > JUMP_SPAN &&
                   d > 3 * longint'(est_srtt) + 2 * longint'(est_dev)) begin
        st = STATUS_BOGUS_JUMP;
      end else begin
        st = STATUS_ACCEPTED;
      end
      srtt_n = longint'(est_srtt) + (d >>> 3);
      mag = (d < 0) ? -d : d;
      dev_n = longint'(est_dev) + ((mag - longint'(est_dev)) >>> 2);
    end
    if (st == STATUS_SEEDED || st == STATUS_ACCEPTED) begin
      // The timeout sees the variance before it is clipped.
      tmo = srtt_n + 4 * dev_n;
      if (dev_n > DEV_TRIP) dev_n = DEV_CLIPPED;
      lo = longint'(win_min_ms) * 1000;
      hi = longint'(win_max_ms) * 1000;
      if (tmo > hi) begin
        tmo = hi;
      end else if (tmo < lo) begin
        tmo = lo;
      end
      if (win_delay_ms != 0 && tmo < longint'(win_delay_ms) * 1000) begin
        tmo = longint'(win_delay_ms) * 1000;
      end
      est_srtt = int'(srtt_n);
      est_dev = int'(dev_n);
      est_tmo = int'(tmo);
      est_valid = 1'b1;
    end
    status_count[st]++;
    r.srtt = est_srtt;
    r.rtt_dev = est_dev[30:0];
    r.timeout = est_tmo[30:0];
    r.status = st;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      est_valid = 1'b0;
      est_srtt = 0;
      est_dev = 0;
      est_tmo = 0;
      win_initial_ms = CFG_W'(1000);
      win_min_ms = CFG_W'(100);
      win_max_ms = CFG_W'(10000);
      win_delay_ms = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INITIAL_TIMEOUT: win_initial_ms = cfg_wdata;
          CFG_MIN_TIMEOUT:     win_min_ms = cfg_wdata;
          CFG_MAX_TIMEOUT:     win_max_ms = cfg_wdata;
          CFG_SCAN_DELAY:      win_delay_ms = cfg_wdata;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        pending_q.push_back(estimate_rtt(in_if.sent_time_us, in_if.recv_time_us));
      end
    end
  end

  // Stimulus choices read a copy taken away from the sampling edge.
  always @(negedge clk) begin
    gen_srtt = est_srtt;
    gen_dev = est_dev;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: srtt %0d dev %0d timeout %0d status %0d",
                 $time, out_if.smoothed_rtt_us, out_if.rtt_variance_us,
                 out_if.timeout_us, out_if.sample_status);
        errors++;
      end else begin
        oldest = pending_q.pop_front();
        if (out_if.smoothed_rtt_us !== oldest.srtt) begin
          $display("%0t: smoothed_rtt_us expected %0d actual %0d",
                   $time, oldest.srtt, out_if.smoothed_rtt_us);
          errors++;
        end
        if (out_if.rtt_variance_us !== oldest.rtt_dev) begin
          $display("%0t: rtt_variance_us expected %0d actual %0d",
                   $time, oldest.rtt_dev, out_if.rtt_variance_us);
          errors++;
        end
        if (out_if.timeout_us !== oldest.timeout) begin
          $display("%0t: timeout_us expected %0d actual %0d",
                   $time, oldest.timeout, out_if.timeout_us);
          errors++;
        end
        if (out_if.sample_status !== oldest.status) begin
          $display("%0t: sample_status expected %s actual %0d",
                   $time, oldest.status.name(), out_if.sample_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : receiver
    rx_pattern_t pattern;
    int          span;
    int          phase;
    phase = 0;
    out_if.ready = 1'b0;
    forever begin
      pattern = rx_pattern_t'($urandom_range(0, 3));
      span = $urandom_range(32, 128);
      repeat (span) begin
        @(negedge clk);
        phase++;
        case (pattern)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= (phase % 8 == 0);
        endcase
      end
    end
  end

  task automatic send_probe(input logic [TIME_W-1:0] sent, input logic [TIME_W-1:0] recv);
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.sent_time_us <= sent;
    in_if.recv_time_us <= recv;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    probes_accepted++;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_rtt(input longint delta);
    longint s;
    s = longint'({16'($urandom), 32'($urandom)});
    if (delta > 0 && s > STAMP_MAX - delta) s = s - delta;
    if (delta < 0 && s < -delta) s = s - delta;
    send_probe(s[TIME_W-1:0], TIME_W'(s + delta));
  endtask

  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_window(input logic [CFG_W-1:0] init_ms, input logic [CFG_W-1:0] min_ms,
                              input logic [CFG_W-1:0] max_ms,
                              input logic [CFG_W-1:0] delay_ms);
    write_reg(CFG_INITIAL_TIMEOUT, init_ms);
    write_reg(CFG_MIN_TIMEOUT, min_ms);
    write_reg(CFG_MAX_TIMEOUT, max_ms);
    write_reg(CFG_SCAN_DELAY, delay_ms);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    windows_applied++;
  endtask

  function automatic logic [CFG_W-1:0] pick_window_ms();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_W'(100000);
      2:       return CFG_W'($urandom_range(0, 3000));
      default: return CFG_W'($urandom_range(0, 100000));
    endcase
  endfunction

  function automatic longint track_delta();
    longint base;
    longint spread;
    longint delta;
    base = (gen_srtt < 0) ? 0 : longint'(gen_srtt);
    spread = base / 2 + 20000;
    delta = base - spread + longint'($urandom_range(0, 32'(2 * spread)));
    if (delta < 0) delta = -delta;
    if (delta >= RTT_CEILING) delta = RTT_CEILING - 1;
    return delta;
  endfunction

  // Largest step that still passes the jump test, so the variance grows fast.
  function automatic longint climb_delta();
    longint jump;
    longint delta;
    jump = 3 * longint'(gen_srtt) + 2 * longint'(gen_dev);
    if (jump < JUMP_SPAN) jump = JUMP_SPAN;
    delta = longint'(gen_srtt) + jump;
    if (delta >= RTT_CEILING) delta = RTT_CEILING - 1;
    if (delta < 0) delta = 0;
    return delta;
  endfunction

  task automatic random_probe();
    longint           delta;
    longint           bound;
    int               pick;
    logic [TIME_W-1:0] stamp;
    pick = $urandom_range(0, 99);
    bound = 4 * longint'(gen_srtt) + 2 * longint'(gen_dev) + 1;
    stamp = {16'($urandom), 32'($urandom)};
    if (pick < 45) begin
      delta = track_delta();
    end else if (pick < 53) begin
      delta = climb_delta();
    end else if (pick < 58) begin
      delta = $urandom_range(0, 20000);
    end else if (pick < 66) begin
      delta = $urandom_range(0, 7999999);
    end else if (pick < 72) begin
      delta = -longint'($urandom_range(1, 49999));
    end else if (pick < 77) begin
      delta = -(NEG_WINDOW + (longint'($urandom) << $urandom_range(0, 14)));
    end else if (pick < 82) begin
      delta = RTT_CEILING + (longint'($urandom) << $urandom_range(0, 14));
    end else if (pick < 90) begin
      if (bound < longint'(gen_srtt) + JUMP_SPAN + 1) bound = longint'(gen_srtt) + JUMP_SPAN + 1;
      delta = bound + $urandom_range(0, 200000);
    end else if (pick < 96) begin
      case ($urandom_range(0, 9))
        0:       delta = -NEG_WINDOW;
        1:       delta = -NEG_WINDOW + 1;
        2:       delta = RTT_CEILING - 1;
        3:       delta = RTT_CEILING;
        4:       delta = longint'(gen_srtt) + JUMP_SPAN;
        5:       delta = INT32_HI;
        6:       delta = INT32_HI + 1;
        7:       delta = INT32_LO;
        8:       delta = INT32_LO - 1;
        default: delta = bound - 1;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       send_probe('0, TIME_W'(STAMP_MAX));
        1:       send_probe(TIME_W'(STAMP_MAX), '0);
        default: send_probe(stamp, stamp);
      endcase
      return;
    end
    send_rtt(delta);
  endtask

  task automatic test_first_sample();
    send_probe(TIME_W'(STAMP_MAX), TIME_W'(STAMP_MAX - 20000));
    settle();
  endtask

  task automatic test_delta_edges();
    send_probe('0, '0);
    send_probe('0, TIME_W'(STAMP_MAX));
    send_probe(TIME_W'(STAMP_MAX), '0);
    send_rtt(-NEG_WINDOW + 1);
    send_rtt(-NEG_WINDOW);
    send_rtt(-1);
    send_rtt(RTT_CEILING - 1);
    send_rtt(RTT_CEILING);
    settle();
  endtask

  task automatic test_variance_climb();
    repeat (5) begin
      settle();
      send_rtt(climb_delta());
    end
    repeat (2) send_rtt(0);
    settle();
  endtask

  task automatic test_timeout_window();
    apply_window('0, '0, CFG_W'(100000), '0);
    repeat (2) send_rtt(track_delta());
    settle();
    apply_window(CFG_W'(100000), CFG_W'(100000), '0, '0);
    repeat (2) send_rtt(track_delta());
    settle();
    apply_window(CFG_W'(50000), '0, '0, CFG_W'(100000));
    repeat (2) send_rtt(track_delta());
    settle();
    apply_window(CFG_W'(1000), CFG_W'(100), CFG_W'(10000), '0);
  endtask

  task automatic test_random_probes();
    int round;
    for (round = 0; round < WINDOW_ROUNDS; round++) begin
      settle();
      apply_window(pick_window_ms(), pick_window_ms(), pick_window_ms(),
                   ($urandom_range(0, 1) != 0) ? '0 : pick_window_ms());
      sender_gaps = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 16);
      repeat (RANDOM_PROBES / WINDOW_ROUNDS) random_probe();
    end
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_INITIAL_TIMEOUT;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.sent_time_us = '0;
    in_if.recv_time_us = '0;
    burst_left = $urandom_range(1, 16);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apply_window(CFG_W'(100000), CFG_W'(100), CFG_W'(10000), '0);
    test_first_sample();
    test_delta_edges();
    test_variance_climb();
    test_timeout_window();
    test_random_probes();
    repeat (8) @(posedge clk);
    $display("Run covered %0d probes: %0d seeded, %0d accepted, %0d out of range, %0d jumps.",
             probes_accepted, status_count[STATUS_SEEDED], status_count[STATUS_ACCEPTED],
             status_count[STATUS_OUT_OF_RANGE], status_count[STATUS_BOGUS_JUMP]);
    $display("Timeout window reprogrammed %0d times; %0d mismatches found.",
             windows_applied, errors);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
